[design/v3n_pkg.sv]
package v3n_pkg;

  localparam int unsigned CompW     = 16;
  localparam int unsigned UnitFracW = 14;
  localparam int unsigned LenW      = CompW;
  localparam int unsigned SumW      = 2 * CompW;
  localparam int unsigned RemW      = LenW + 2;
  localparam int unsigned SqrtSteps = SumW / 2;
  localparam int unsigned DivSteps  = UnitFracW + 1;
  localparam int unsigned UnitW     = UnitFracW + 2;

  typedef struct packed {
    logic [CompW-1:0] mag_x;
    logic [CompW-1:0] mag_y;
    logic [CompW-1:0] mag_z;
    logic [2:0]       neg;
    logic             zero;
  } vec_t;

  typedef struct packed {
    vec_t            vec;
    logic [SumW-1:0] n;
    logic [RemW-1:0] rem;
    logic [LenW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [LenW-1:0]     rem;
    logic [DivSteps-1:0] rest;
    logic [DivSteps-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0] lane;
    logic [2:0]      neg;
    logic [LenW-1:0] len;
    logic            zero;
  } div_t;

endpackage

[design/v3n_if.sv]
interface v3n_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [v3n_pkg::CompW-1:0]    comp_x;
  logic signed [v3n_pkg::CompW-1:0]    comp_y;
  logic signed [v3n_pkg::CompW-1:0]    comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface v3n_out_if;
  logic                                valid;
  logic                                ready;
  logic [v3n_pkg::LenW-1:0]            length;
  logic signed [v3n_pkg::UnitW-1:0]    unit_x;
  logic signed [v3n_pkg::UnitW-1:0]    unit_y;
  logic signed [v3n_pkg::UnitW-1:0]    unit_z;
  logic                                is_zero;
  modport source (output valid, length, unit_x, unit_y, unit_z, is_zero, input ready);
  modport sink (input valid, length, unit_x, unit_y, unit_z, is_zero, output ready);
endinterface

[design/vector3_normalize.sv]
// Pipeline: square, sum, 16 root cells, 15 divide cells, output register.
// Throughput: one word per cycle; the whole row of cells advances together
// and holds while a result waits at the output.
// Reset: rst_ni clears every valid bit at once; payload registers are not reset.
module vector3_normalize (
  input  logic         clk_i,
  input  logic         rst_ni,
  v3n_in_if.sink       in_s,
  v3n_out_if.source    out_s
);

  localparam int unsigned NSq = v3n_pkg::SqrtSteps;
  localparam int unsigned NDv = v3n_pkg::DivSteps;

  logic adv;
  logic out_valid_q;

  // Square stage
  logic                        sq_valid_q;
  v3n_pkg::vec_t               sq_vec_d, sq_vec_q;
  logic [v3n_pkg::SumW-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [v3n_pkg::CompW-1:0]   raw [3];
  logic [v3n_pkg::CompW-1:0]   mag [3];

  // Sum stage
  logic                        sum_valid_q;
  v3n_pkg::sqrt_t              sum_q;

  logic                        sv [NSq+1];
  v3n_pkg::sqrt_t              sd [NSq+1];
  logic                        dv [NDv+1];
  v3n_pkg::div_t               dd [NDv+1];

  logic [v3n_pkg::LenW-1:0]    len_q;
  logic [v3n_pkg::UnitW-1:0]   unit_q [3];
  logic                        zero_q;
  logic [v3n_pkg::UnitW-1:0]   uq [3];

  assign adv        = !out_valid_q || out_s.ready;
  assign in_s.ready = adv;

  always_comb begin
    raw[0] = in_s.comp_x;
    raw[1] = in_s.comp_y;
    raw[2] = in_s.comp_z;
    for (int i = 0; i < 3; i++) begin
      mag[i] = raw[i][v3n_pkg::CompW-1] ? (~raw[i] + 1'b1) : raw[i];
    end
    sq_vec_d.mag_x = mag[0];
    sq_vec_d.mag_y = mag[1];
    sq_vec_d.mag_z = mag[2];
    sq_vec_d.neg   = {raw[2][v3n_pkg::CompW-1], raw[1][v3n_pkg::CompW-1],
                      raw[0][v3n_pkg::CompW-1]};
    sq_vec_d.zero  = (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      sq_valid_q  <= in_s.valid;
      sum_valid_q <= sq_valid_q;
      out_valid_q <= dv[NDv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_vec_q     <= sq_vec_d;
      sq_x_q       <= mag[0] * mag[0];
      sq_y_q       <= mag[1] * mag[1];
      sq_z_q       <= mag[2] * mag[2];
      sum_q.vec    <= sq_vec_q;
      sum_q.n      <= sq_x_q + sq_y_q + sq_z_q;
      sum_q.rem    <= '0;
      sum_q.root   <= '0;
    end
  end

  assign sv[0] = sum_valid_q;
  assign sd[0] = sum_q;

  for (genvar g = 0; g < NSq; g++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sv[g]),
      .data_i  (sd[g]),
      .valid_o (sv[g+1]),
      .data_o  (sd[g+1])
    );
  end

  // Seed the divide row: remainder starts at mag/2, which is below the length
  always_comb begin
    dd[0].len  = sd[NSq].root;
    dd[0].neg  = sd[NSq].vec.neg;
    dd[0].zero = sd[NSq].vec.zero;
    dd[0].lane[0].rem  = {1'b0, sd[NSq].vec.mag_x[v3n_pkg::CompW-1:1]};
    dd[0].lane[1].rem  = {1'b0, sd[NSq].vec.mag_y[v3n_pkg::CompW-1:1]};
    dd[0].lane[2].rem  = {1'b0, sd[NSq].vec.mag_z[v3n_pkg::CompW-1:1]};
    dd[0].lane[0].rest = {sd[NSq].vec.mag_x[0], {v3n_pkg::UnitFracW{1'b0}}};
    dd[0].lane[1].rest = {sd[NSq].vec.mag_y[0], {v3n_pkg::UnitFracW{1'b0}}};
    dd[0].lane[2].rest = {sd[NSq].vec.mag_z[0], {v3n_pkg::UnitFracW{1'b0}}};
    dd[0].lane[0].quo  = '0;
    dd[0].lane[1].quo  = '0;
    dd[0].lane[2].quo  = '0;
  end
  assign dv[0] = sv[NSq];

  for (genvar g = 0; g < NDv; g++) begin : g_div
    v3n_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv[g]),
      .data_i  (dd[g]),
      .valid_o (dv[g+1]),
      .data_o  (dd[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dd[NDv].zero) begin
        uq[i] = '0;
      end else if (dd[NDv].neg[i]) begin
        uq[i] = ~{1'b0, dd[NDv].lane[i].quo} + 1'b1;
      end else begin
        uq[i] = {1'b0, dd[NDv].lane[i].quo};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q  <= dd[NDv].len;
      zero_q <= dd[NDv].zero;
      for (int i = 0; i < 3; i++) begin
        unit_q[i] <= uq[i];
      end
    end
  end

  assign out_s.valid   = out_valid_q;
  assign out_s.length  = len_q;
  assign out_s.unit_x  = unit_q[0];
  assign out_s.unit_y  = unit_q[1];
  assign out_s.unit_z  = unit_q[2];
  assign out_s.is_zero = zero_q;

endmodule

[design/v3n_sqrt_cell.sv]
module v3n_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  v3n_pkg::sqrt_t  data_i,
  output logic            valid_o,
  output v3n_pkg::sqrt_t  data_o
);

  logic [v3n_pkg::RemW+1:0] cat;
  logic [v3n_pkg::RemW+1:0] trial;
  logic [v3n_pkg::RemW+1:0] diff;
  v3n_pkg::sqrt_t           data_d, data_q;
  logic                     valid_q;

  always_comb begin
    cat    = {data_i.rem, data_i.n[v3n_pkg::SumW-1 -: 2]};
    trial  = {2'b00, data_i.root, 2'b01};
    diff   = cat - trial;
    data_d = data_i;
    data_d.n = {data_i.n[v3n_pkg::SumW-3:0], 2'b00};
    if (cat >= trial) begin
      data_d.rem  = diff[v3n_pkg::RemW-1:0];
      data_d.root = {data_i.root[v3n_pkg::LenW-2:0], 1'b1};
    end else begin
      data_d.rem  = cat[v3n_pkg::RemW-1:0];
      data_d.root = {data_i.root[v3n_pkg::LenW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/v3n_div_cell.sv]
module v3n_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  v3n_pkg::div_t  data_i,
  output logic           valid_o,
  output v3n_pkg::div_t  data_o
);

  logic [v3n_pkg::LenW:0] part [3];
  logic [v3n_pkg::LenW:0] diff [3];
  v3n_pkg::div_t          data_d, data_q;
  logic                   valid_q;

  always_comb begin
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      part[i] = {data_i.lane[i].rem, data_i.lane[i].rest[v3n_pkg::DivSteps-1]};
      diff[i] = part[i] - {1'b0, data_i.len};
      data_d.lane[i].rest = {data_i.lane[i].rest[v3n_pkg::DivSteps-2:0], 1'b0};
      if (part[i] >= {1'b0, data_i.len}) begin
        data_d.lane[i].rem = diff[i][v3n_pkg::LenW-1:0];
        data_d.lane[i].quo = {data_i.lane[i].quo[v3n_pkg::DivSteps-2:0], 1'b1};
      end else begin
        data_d.lane[i].rem = part[i][v3n_pkg::LenW-1:0];
        data_d.lane[i].quo = {data_i.lane[i].quo[v3n_pkg::DivSteps-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
